// ===== hdl/tpd_pkg.sv =====
// Shared types and constants for the tree path distance block.
package tpd_pkg;

    localparam int unsigned NODE_W = 7;
    localparam int unsigned WEIGHT_W = 16;
    localparam int unsigned DIST_W = 22;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD2,
        ST_INIT,
        ST_FRAME,
        ST_SCAN,
        ST_CHECK,
        ST_PUSH,
        ST_DONE
    } tpd_state_t;

endpackage

// ===== hdl/tree_path_distance_query.sv =====
// Tree path distance block: edge loads into an adjacency memory and depth-first
// walks that answer weighted path distance queries.
//
// An edge load (op 0) writes the weight into both directions of the node pair in
// the adjacency memory, one direction per cycle, and gives no result. Loads with
// an endpoint of 0 or above MAX_NODES are dropped. A query (op 1) walks
// depth-first from node_a with a stack kept in small frame memories. The
// adjacency memory has one registered read port and the scan reads one neighbor
// entry every cycle while no unvisited neighbor turns up, over n =
// min(num_nodes, MAX_NODES) entries per node; a query with bad or equal nodes
// goes straight to the result. One item is worked on at a time. After reset
// the block clears all 2**(2*clog2(MAX_NODES)) adjacency entries (4096 at 64
// nodes), one entry a cycle, and accepts no item during that pass; num_nodes
// writes are taken at all times. The result waits in an output register until
// taken; sums saturate at 4194303.
module tree_path_distance_query #(
    parameter int unsigned MAX_NODES = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [tpd_pkg::NODE_W-1:0]   cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         op,
    input  logic [tpd_pkg::NODE_W-1:0]   node_a,
    input  logic [tpd_pkg::NODE_W-1:0]   node_b,
    input  logic [tpd_pkg::WEIGHT_W-1:0] weight,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tpd_pkg::DIST_W-1:0]   distance,
    output logic                         found
);
    import tpd_pkg::*;

    localparam int unsigned IW = $clog2(MAX_NODES);     // node index width
    localparam int unsigned AW = 2 * IW;                // adjacency address
    localparam int unsigned CW = IW + 1;                // cursor, holds n
    localparam int unsigned DEPTH = 1 << AW;
    localparam int unsigned EW = WEIGHT_W + 1;
    localparam int unsigned QW = (NODE_W > CW) ? NODE_W : CW;

    // adjacency memory: valid bit over weight
    logic [EW-1:0] adj_mem [DEPTH];
    logic [EW-1:0] adj_rd_reg;
    logic          adj_we;
    logic [AW-1:0] adj_waddr;
    logic [EW-1:0] adj_wdata;
    logic          adj_re;
    logic [AW-1:0] adj_raddr;

    // walk frame memories
    logic [IW-1:0]     node_mem [MAX_NODES];
    logic [CW-1:0]     cur_mem  [MAX_NODES];
    logic [DIST_W-1:0] sum_mem  [MAX_NODES];
    logic              frm_we;
    logic [IW-1:0]     frm_waddr;
    logic [IW-1:0]     frm_node_w;
    logic [CW-1:0]     frm_cur_w;
    logic [DIST_W-1:0] frm_sum_w;
    logic [IW-1:0]     frm_raddr;
    logic [IW-1:0]     frm_node_rd_reg;
    logic [CW-1:0]     frm_cur_rd_reg;
    logic [DIST_W-1:0] frm_sum_rd_reg;

    tpd_state_t state_reg, state_next;
    logic [NODE_W-1:0]   num_nodes_reg;
    logic [AW:0]         clr_reg, clr_next;
    logic [MAX_NODES-1:0] visited_reg, visited_next;
    logic [CW-1:0]       depth_reg, depth_next;   // frames on stack
    logic [CW-1:0]       j_reg, j_next;           // neighbor being scanned
    logic [IW-1:0]       u_reg, u_next;
    logic [DIST_W-1:0]   base_reg, base_next;     // sum at current frame
    logic [IW-1:0]       a_reg, a_next, b_reg, b_next;
    logic [EW-1:0]       w_reg, w_next;
    logic                pend_reg, pend_next;     // adjacency read in flight
    logic [CW-1:0]       pend_j_reg, pend_j_next;
    logic [DIST_W-1:0]   s_reg, s_next;
    logic                out_valid_reg, out_valid_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic                found_reg, found_next;

    logic [CW-1:0]  n_eff;
    logic           in_acc;
    logic           a_ok_ld, b_ok_ld, a_ok_q, b_ok_q;
    logic [DIST_W:0] sum_wide;

    assign n_eff = (QW'(num_nodes_reg) < QW'(MAX_NODES)) ? CW'(num_nodes_reg)
                                                         : CW'(MAX_NODES);
    assign in_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_acc   = in_valid && in_ready;
    assign a_ok_ld  = (node_a != '0) && (QW'(node_a) <= QW'(MAX_NODES));
    assign b_ok_ld  = (node_b != '0) && (QW'(node_b) <= QW'(MAX_NODES));
    assign a_ok_q   = (node_a != '0) && (QW'(node_a) <= QW'(n_eff));
    assign b_ok_q   = (node_b != '0) && (QW'(node_b) <= QW'(n_eff));
    assign sum_wide = {1'b0, base_reg} + (DIST_W+1)'(adj_rd_reg[WEIGHT_W-1:0]);

    assign out_valid = out_valid_reg;
    assign distance  = dist_reg;
    assign found     = found_reg;

    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        if (adj_re)
        begin
            adj_rd_reg <= adj_mem[adj_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (frm_we)
        begin
            node_mem[frm_waddr] <= frm_node_w;
            cur_mem[frm_waddr]  <= frm_cur_w;
            sum_mem[frm_waddr]  <= frm_sum_w;
        end
        frm_node_rd_reg <= node_mem[frm_raddr];
        frm_cur_rd_reg  <= cur_mem[frm_raddr];
        frm_sum_rd_reg  <= sum_mem[frm_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            num_nodes_reg <= NODE_W'(64);
            clr_reg       <= '0;
            visited_reg   <= '0;
            depth_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                num_nodes_reg <= cfg_wdata;
            end
            clr_reg       <= clr_next;
            visited_reg   <= visited_next;
            depth_reg     <= depth_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg      <= j_next;
        u_reg      <= u_next;
        base_reg   <= base_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        w_reg      <= w_next;
        pend_j_reg <= pend_j_next;
        s_reg      <= s_next;
        dist_reg   <= dist_next;
        found_reg  <= found_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == (AW+1)'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (op == OP_LOAD)
                    begin
                        state_next = (a_ok_ld && b_ok_ld) ? ST_LOAD2 : ST_IDLE;
                    end
                    else if (a_ok_q && b_ok_q && node_a != node_b)
                    begin
                        state_next = ST_INIT;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_LOAD2: state_next = ST_IDLE;
            ST_INIT:  state_next = ST_SCAN;
            ST_FRAME: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (pend_reg && adj_rd_reg[WEIGHT_W] && !visited_reg[pend_j_reg[IW-1:0]])
                begin
                    state_next = ST_CHECK;
                end
                else if (!pend_reg && j_reg >= n_eff)
                begin
                    state_next = (depth_reg == CW'(1)) ? ST_DONE : ST_FRAME;
                end
            end
            ST_CHECK: state_next = (pend_j_reg[IW-1:0] == b_reg) ? ST_DONE : ST_PUSH;
            ST_PUSH:  state_next = ST_SCAN;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        clr_next       = clr_reg;
        visited_next   = visited_reg;
        depth_next     = depth_reg;
        j_next         = j_reg;
        u_next         = u_reg;
        base_next      = base_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        w_next         = w_reg;
        pend_next      = 1'b0;
        pend_j_next    = pend_j_reg;
        s_next         = s_reg;
        out_valid_next = out_valid_reg && !out_ready;
        dist_next      = dist_reg;
        found_next     = found_reg;
        adj_we         = 1'b0;
        adj_waddr      = '0;
        adj_wdata      = '0;
        adj_re         = 1'b0;
        adj_raddr      = {u_reg, j_reg[IW-1:0]};
        frm_we         = 1'b0;
        frm_waddr      = '0;
        frm_node_w     = '0;
        frm_cur_w      = '0;
        frm_sum_w      = '0;
        frm_raddr      = IW'(depth_reg - CW'(1));
        case (state_reg)
            ST_CLEAR:
            begin
                adj_we    = 1'b1;
                adj_waddr = clr_reg[AW-1:0];
                adj_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    a_next     = IW'(node_a - 1'b1);
                    b_next     = IW'(node_b - 1'b1);
                    w_next     = {1'b1, weight};
                    dist_next  = '0;
                    found_next = a_ok_q && b_ok_q && (node_a == node_b);
                    if (op == OP_LOAD && a_ok_ld && b_ok_ld)
                    begin
                        adj_we    = 1'b1;
                        adj_waddr = {IW'(node_a - 1'b1), IW'(node_b - 1'b1)};
                        adj_wdata = {1'b1, weight};
                    end
                end
            end
            ST_LOAD2:
            begin
                adj_we    = 1'b1;
                adj_waddr = {b_reg, a_reg};
                adj_wdata = w_reg;
            end
            ST_INIT:
            begin
                // root frame goes to memory and straight into the scan registers
                visited_next        = '0;
                visited_next[a_reg] = 1'b1;
                frm_we     = 1'b1;
                frm_waddr  = '0;
                frm_node_w = a_reg;
                frm_cur_w  = '0;
                frm_sum_w  = '0;
                depth_next = CW'(1);
                u_next     = a_reg;
                j_next     = '0;
                base_next  = '0;
            end
            ST_FRAME:
            begin
                // frame read data lands now
                u_next    = frm_node_rd_reg;
                j_next    = frm_cur_rd_reg;
                base_next = frm_sum_rd_reg;
            end
            ST_SCAN:
            begin
                if (pend_reg && adj_rd_reg[WEIGHT_W] && !visited_reg[pend_j_reg[IW-1:0]])
                begin
                    // hit: saturate sum, cursor resumes after this neighbor
                    s_next = sum_wide[DIST_W] ? DIST_MAX : sum_wide[DIST_W-1:0];
                    visited_next[pend_j_reg[IW-1:0]] = 1'b1;
                    j_next = pend_j_reg + 1'b1;
                end
                else if (j_reg < n_eff)
                begin
                    adj_re      = 1'b1;
                    pend_next   = 1'b1;
                    pend_j_next = j_reg;
                    j_next      = j_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    // pop frame; read the one below
                    depth_next = depth_reg - 1'b1;
                    frm_raddr  = IW'(depth_reg - CW'(2));
                end
            end
            ST_CHECK:
            begin
                // save cursor of current frame
                frm_we     = 1'b1;
                frm_waddr  = IW'(depth_reg - CW'(1));
                frm_node_w = u_reg;
                frm_cur_w  = j_reg;
                frm_sum_w  = base_reg;
                if (pend_j_reg[IW-1:0] == b_reg)
                begin
                    dist_next  = s_reg;
                    found_next = 1'b1;
                end
            end
            ST_PUSH:
            begin
                if (depth_reg < CW'(MAX_NODES))
                begin
                    frm_we     = 1'b1;
                    frm_waddr  = IW'(depth_reg);
                    frm_node_w = pend_j_reg[IW-1:0];
                    frm_cur_w  = '0;
                    frm_sum_w  = s_reg;
                    depth_next = depth_reg + 1'b1;
                    u_next     = pend_j_reg[IW-1:0];
                    j_next     = '0;
                    base_next  = s_reg;
                end
            end
            ST_DONE:
            begin
                depth_next     = '0;
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hdl/tpd_checker.sv =====
// Port-level checker for the tree path distance block, bound to the top level.
module tpd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         op,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [tpd_pkg::DIST_W-1:0]   distance,
    input logic                         found
);
    import tpd_pkg::*;

    a_no_dist_without_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> distance == '0)
        else $error("nonzero distance without found");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(found))
        else $error("result changed while stalled");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == OP_LOAD && !out_valid |=> !out_valid)
        else $error("edge load produced a result");

    a_busy_after_query: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == OP_QUERY |=> !in_ready)
        else $error("input taken during query");

endmodule

bind tree_path_distance_query tpd_checker u_tpd_checker (.*);

// ===== dv/tb_tree_path_distance_query.sv =====
// Testbench for tree_path_distance_query: directed and random edge/query items, scoreboard check.
module tb_tree_path_distance_query;
    import tpd_pkg::*;

    localparam int NODES_MAX  = 64;
    localparam int STALL_LIMIT = 40000;   // cycles with no item moving
    localparam int SETTLE_CYCLES = 12;    // lets a trailing edge load finish; a load gives no result

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              found;
    } answer_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [NODE_W-1:0]   cfg_wdata;
    logic                in_valid;
    logic                in_ready;
    logic                op;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] weight;
    logic                out_valid;
    logic                out_ready;
    logic [DIST_W-1:0]   distance;
    logic                found;

    // Shadow of the block: adjacency, node count
    bit                  adj_ok [NODES_MAX][NODES_MAX];
    logic [WEIGHT_W-1:0] adj_w  [NODES_MAX][NODES_MAX];
    int unsigned         shadow_nodes;

    answer_t answers_due[$];
    int      errors;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      recv_hold;       // long receiver hold-off, counted down per cycle
    int      hold_len;        // requested hold-off length
    int      hold_seq;        // bumped to request a hold-off
    int      hold_seq_seen;
    int      quiet_cycles;

    tree_path_distance_query i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .node_a    (node_a),
        .node_b    (node_b),
        .weight    (weight),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .distance  (distance),
        .found     (found)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Depth-first walk over the shadow adjacency, neighbors tried in ascending
    // order, first path found wins; sums saturate at the 22-bit maximum.
    function automatic answer_t walk_distance(input logic [NODE_W-1:0] a,
                                              input logic [NODE_W-1:0] b);
        answer_t ans;
        int      n;
        int      depth;
        int      top;
        int      u;
        int      j;
        int      s;
        int      frame_node [NODES_MAX];
        int      frame_next [NODES_MAX];
        int      frame_sum  [NODES_MAX];
        bit      seen [NODES_MAX];
        ans = '0;
        n = (shadow_nodes < NODES_MAX) ? shadow_nodes : NODES_MAX;
        if (a < 1 || a > n || b < 1 || b > n)
            return ans;
        if (a == b)
        begin
            ans.found = 1'b1;
            return ans;
        end
        foreach (seen[k])
            seen[k] = 1'b0;
        seen[a-1] = 1'b1;
        frame_node[0] = a - 1;
        frame_next[0] = 0;
        frame_sum[0]  = 0;
        depth = 1;
        while (depth > 0)
        begin
            top = depth - 1;
            u = frame_node[top];
            j = frame_next[top];
            while (j < n && (seen[j] || !adj_ok[u][j]))
                j++;
            if (j >= n)
            begin
                depth--;
                continue;
            end
            frame_next[top] = j + 1;
            seen[j] = 1'b1;
            s = frame_sum[top] + int'(adj_w[u][j]);
            if (s > int'(DIST_MAX))
                s = int'(DIST_MAX);
            if (j == b - 1)
            begin
                ans.distance = DIST_W'(s);
                ans.found = 1'b1;
                return ans;
            end
            if (depth < NODES_MAX)
            begin
                frame_node[depth] = j;
                frame_next[depth] = 0;
                frame_sum[depth]  = s;
                depth++;
            end
        end
        return ans;
    endfunction

    // Drive one item, hold it until accepted, then update the shadow.
    task automatic send_item(input logic o, input logic [NODE_W-1:0] a,
                             input logic [NODE_W-1:0] b, input logic [WEIGHT_W-1:0] w);
        int gap;
        in_valid <= 1'b1;
        op       <= o;
        node_a   <= a;
        node_b   <= b;
        weight   <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (o == OP_LOAD)
        begin
            if (a >= 1 && a <= NODES_MAX && b >= 1 && b <= NODES_MAX)
            begin
                adj_ok[a-1][b-1] = 1'b1;
                adj_w[a-1][b-1]  = w;
                adj_ok[b-1][a-1] = 1'b1;
                adj_w[b-1][a-1]  = w;
            end
        end
        else
            answers_due.push_back(walk_distance(a, b));
        // Random sender gap; with no gap valid just stays high for the next item
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load_edge(input int a, input int b, input int w);
        send_item(OP_LOAD, NODE_W'(a), NODE_W'(b), WEIGHT_W'(w));
    endtask

    task automatic query(input int a, input int b);
        send_item(OP_QUERY, NODE_W'(a), NODE_W'(b), WEIGHT_W'($urandom_range(16'hffff)));
    endtask

    // Wait until the block has nothing in flight, then write num_nodes.
    task automatic set_node_count(input int unsigned value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= NODE_W'(value);
        shadow_nodes = value & 7'h7f;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // Random tree over nodes 1..n: node k hangs off a random earlier node
    task automatic grow_tree(input int n, input int max_w);
        for (int k = 2; k <= n; k++)
            load_edge(k, $urandom_range(1, k - 1), $urandom_range(max_w));
    endtask

    task automatic test_directed();
        set_node_count(8);
        query(1, 2);                 // empty store: unreachable
        query(3, 3);                 // same node
        load_edge(1, 2, 16'hffff);
        load_edge(2, 3, 0);
        load_edge(3, 4, 16'h0001);
        load_edge(4, 4, 16'h1234);   // self edge, never walked
        load_edge(2, 3, 16'haaaa);   // overwrite
        load_edge(0, 5, 16'h5555);   // dropped endpoint
        load_edge(5, 65, 16'h5555);  // dropped endpoint
        load_edge(6, 64, 16'h0100);  // stored beyond num_nodes
        load_edge(5, 6, 16'h0200);
        load_edge(1, 5, 16'h0300);
        query(1, 4);
        query(4, 1);
        query(1, 6);
        query(1, 64);                // target above n
        query(0, 2);                 // start of zero
        query(127, 1);
        query(1, 7);                 // unreachable in range
        load_edge(4, 6, 16'h0007);   // closes a cycle
        query(3, 6);
        query(8, 8);
    endtask

    task automatic test_node_count_sweep();
        set_node_count(1);
        query(1, 1);
        query(1, 2);
        set_node_count(0);           // nothing in range
        query(1, 1);
        query(1, 2);
        set_node_count(127);         // clamps to the full store
        query(1, 64);
        query(6, 64);
        set_node_count(64);
        query(6, 64);
        query(64, 64);
    endtask

    // Full-length chain with maximum weights: the largest reachable distance
    task automatic test_longest_path();
        set_node_count(64);
        for (int k = 1; k < 64; k++)
            load_edge(k, k + 1, 16'hffff);
        query(1, 64);
        query(64, 1);
        query(32, 64);
    endtask

    // Mostly well-formed: fresh tree, then queries; some noise and broken loads
    task automatic test_random_trees(input int rounds);
        int n;
        for (int r = 0; r < rounds; r++)
        begin
            n = $urandom_range(2, 14);
            set_node_count(n);
            grow_tree(n, ($urandom_range(3) == 0) ? 16'hffff : 255);
            for (int q = 0; q < 12; q++)
            begin
                case ($urandom_range(9))
                    0: send_item(1'($urandom_range(1)), NODE_W'($urandom_range(127)),
                                 NODE_W'($urandom_range(127)),
                                 WEIGHT_W'($urandom_range(16'hffff)));
                    1: load_edge($urandom_range(1, n), $urandom_range(1, n),
                                 $urandom_range(16'hffff));
                    default: query($urandom_range(1, n), $urandom_range(1, n));
                endcase
            end
        end
    endtask

    // Receiver holds off while the sender keeps offering queries
    task automatic test_backpressure();
        set_node_count(6);
        grow_tree(6, 16'hffff);
        hold_len = 400;
        hold_seq++;
        for (int q = 0; q < 10; q++)
            query($urandom_range(1, 6), $urandom_range(1, 6));
        set_node_count(64);
        query(1, 64);
        query(64, $urandom_range(1, 63));
    endtask

    // Receiver: random stalls, or a counted hold-off
    always @(posedge clk)
    begin
        if (hold_seq != hold_seq_seen)
        begin
            out_ready     <= 1'b0;
            recv_hold     <= hold_len - 1;
            hold_seq_seen <= hold_seq;
        end
        else if (recv_hold > 0)
        begin
            out_ready <= 1'b0;
            recv_hold <= recv_hold - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result check against the oldest expected answer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (answers_due.size() == 0)
                report_mismatch("unexpected result, distance", int'(distance), 0);
            else
            begin
                answer_t want;
                want = answers_due.pop_front();
                if (distance !== want.distance)
                    report_mismatch("distance", int'(distance), int'(want.distance));
                if (found !== want.found)
                    report_mismatch("found", int'(found), int'(want.found));
            end
        end
    end

    // Watchdog on cycles where work is pending but no item moves
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)
            || (!in_valid && answers_due.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        op = OP_LOAD;
        node_a = '0;
        node_b = '0;
        weight = '0;
        hold_len = 0;
        hold_seq = 0;
        shadow_nodes = 64;
        foreach (adj_ok[i, j])
        begin
            adj_ok[i][j] = 1'b0;
            adj_w[i][j] = '0;
        end
        send_idle_pct = 37;
        recv_idle_pct = 46;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_node_count_sweep();
        test_random_trees(1);
        send_idle_pct = 46;
        recv_idle_pct = 37;
        test_longest_path();
        test_random_trees(1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();

        in_valid <= 1'b0;
        @(posedge clk);
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/tpd_pkg.sv
hdl/tree_path_distance_query.sv
hdl/tpd_checker.sv
dv/tb_tree_path_distance_query.sv
